// ----- rtl/servo_angle_packet_framer_top_defines.svh -----
// Assertion helpers for the framer RTL; only the queue uses them.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SERVO_ANGLE_PACKET_FRAMER_TOP_DEFINES_SVH
`define SERVO_ANGLE_PACKET_FRAMER_TOP_DEFINES_SVH

// Property must hold at every rising clock edge outside reset.
`define SAPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SAPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/sapf_pkg.sv -----
`default_nettype none
package sapf_pkg;

  // Packet geometry
  localparam int unsigned JOINT_COUNT    = 18;
  localparam int unsigned JOINTS_PER_LEG = 3;
  localparam int unsigned JOINT_W        = 5;
  localparam int unsigned LEG_W          = 4;
  localparam int unsigned J_W            = 2;

  // Value path
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned PROD_W   = 49;
  localparam int unsigned VAL_W    = 20;
  localparam logic [32:0] DEG100_PER_RAD_Q20 = 33'd6007897930;
  localparam logic signed [VAL_W-1:0] HALF_TURN = 20'sd18000;
  localparam logic signed [VAL_W-1:0] FULL_TURN = 20'sd36000;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = 20'sd65535;

  // Decoupling queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEND_ENABLE   = 2'd0,
    CFG_START_BYTE    = 2'd1,
    CFG_HIP_SWING     = 2'd2,
    CFG_JOINT_CEILING = 2'd3
  } cfg_idx_e;

  // Byte position inside the packet sequence of one joint
  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_HIGH  = 2'd1,
    POS_LOW   = 2'd2,
    POS_SUM   = 2'd3
  } pos_e;

  typedef struct packed {
    logic        send_enable;
    logic [7:0]  start_byte;
    logic [14:0] hip_swing;
    logic [15:0] joint_ceiling;
  } cfg_t;

  // Per-joint classification carried down the front pipeline
  typedef struct packed {
    logic [J_W-1:0] j;
    logic           mirror;
    logic           first;
    logic           last;
  } meta_t;

  // One queued joint for the byte sequencer
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  sum;
    logic        first;
    logic        last;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/servo_angle_packet_framer_top.sv -----
// An accepted joint passes the stage 1, stage 2 and queue entry registers before its
// first byte reaches the output.
// Throughput: the input takes one word per cycle while the four-entry queue has room;
// the byte channel sends two words per joint, three for the first and last joint,
// so the sustained joint rate is set by the single byte output.
// Reset (async, active low): joint counter and checksum cleared, queue emptied,
// registers back to send on, start 0xA5, hip swing 6000, ceiling 18000.
`default_nettype none
module servo_angle_packet_framer_top import sapf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] joint_angle, [32:16] joint_offset, [39:33] zero
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  // [0] packet_done
  output logic             m_axis_tuser_o
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.send_enable   <= 1'b1;
      cfg_q.start_byte    <= 8'hA5;
      cfg_q.hip_swing     <= 15'd6000;
      cfg_q.joint_ceiling <= 16'd18000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SEND_ENABLE:   cfg_q.send_enable   <= cfg_wdata_i[0];
        CFG_START_BYTE:    cfg_q.start_byte    <= cfg_wdata_i[7:0];
        CFG_HIP_SWING:     cfg_q.hip_swing     <= cfg_wdata_i[14:0];
        CFG_JOINT_CEILING: cfg_q.joint_ceiling <= cfg_wdata_i;
        default:           cfg_q.joint_ceiling <= cfg_q.joint_ceiling;
      endcase
    end
  end

  sapf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .joint_angle_i  ($signed(s_axis_tdata_i[15:0])),
    .joint_offset_i ($signed(s_axis_tdata_i[32:16])),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_item_o    (push_item)
  );

  sapf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  sapf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (cfg_q.start_byte),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_done_o   (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// ----- rtl/sapf_front.sv -----
`default_nettype none
module sapf_front import sapf_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfg_t                       cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [ANGLE_W-1:0]  joint_angle_i,
  input  wire logic signed [OFFSET_W-1:0] joint_offset_i,
  output logic                            push_valid_o,
  input  wire logic                       push_ready_i,
  output item_t                           push_item_o
);

  // Joint position tracking
  logic [JOINT_W-1:0] cnt_q, cnt_d;
  logic [J_W-1:0]     j_q, j_d;
  logic [LEG_W-1:0]   leg_q, leg_d;
  meta_t              meta_in;

  // Stage 1: product
  logic                           s1_v_q;
  logic [PROD_W-1:0]              s1_prod_q;
  logic                           s1_neg_q;
  logic signed [OFFSET_W-1:0]     s1_off_q;
  meta_t                          s1_meta_q;
  logic [ANGLE_W-1:0]             mag;

  // Stage 2: geometry done, limits ready
  logic                    s2_v_q;
  logic signed [VAL_W-1:0] s2_val_q, s2_lo_q, s2_hi_q;
  meta_t                   s2_meta_q;
  logic signed [VAL_W-1:0] val_d, lo_d, hi_d;

  logic [7:0]  running_sum_q;
  logic        s1_ready, s2_ready, s2_leave, accept;
  logic signed [VAL_W-1:0] clamped;
  logic [15:0] value;
  logic [7:0]  sum;

  assign s2_leave   = s2_v_q && (!cfg_i.send_enable || push_ready_i);
  assign s2_ready   = !s2_v_q || s2_leave;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;

  // Classify the incoming joint
  always_comb begin
    meta_in.j      = j_q;
    meta_in.mirror = (leg_q >= LEG_W'(3)) && (leg_q <= LEG_W'(5)) && (j_q != '0);
    meta_in.first  = (cnt_q == '0);
    meta_in.last   = (cnt_q == JOINT_W'(JOINT_COUNT - 1));
  end

  // Counter advance
  always_comb begin
    cnt_d = cnt_q;
    j_d   = j_q;
    leg_d = leg_q;
    if (accept) begin
      if (meta_in.last) begin
        cnt_d = '0;
        j_d   = '0;
        leg_d = '0;
      end else begin
        cnt_d = cnt_q + JOINT_W'(1);
        if (j_q == J_W'(JOINTS_PER_LEG - 1)) begin
          j_d   = '0;
          leg_d = leg_q + LEG_W'(1);
        end else begin
          j_d = j_q + J_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      j_q   <= '0;
      leg_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      j_q   <= j_d;
      leg_q <= leg_d;
    end
  end

  // Stage 1: magnitude times scale
  assign mag = joint_angle_i[ANGLE_W-1] ? (~joint_angle_i + ANGLE_W'(1)) : joint_angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_prod_q <= PROD_W'(mag) * PROD_W'(DEG100_PER_RAD_Q20);
      s1_neg_q  <= joint_angle_i[ANGLE_W-1];
      s1_off_q  <= joint_offset_i;
      s1_meta_q <= meta_in;
    end
  end

  // Stage 2: round, sign, joint geometry and clamp limits
  always_comb begin
    logic [16:0]             rnd;
    logic signed [VAL_W-1:0] rs, off, hs, v;
    rnd = s1_prod_q[48:32] + {16'd0, s1_prod_q[31]};
    rs  = $signed({3'b000, rnd});
    if (s1_neg_q) begin
      rs = -rs;
    end
    off = VAL_W'(s1_off_q);
    hs  = $signed({5'b00000, cfg_i.hip_swing});
    v   = (s1_meta_q.j == J_W'(2)) ? (FULL_TURN - rs) : rs;
    v   = v + off;
    if (s1_meta_q.mirror) begin
      v = HALF_TURN - v;
    end
    val_d = v;
    if (s1_meta_q.j == '0) begin
      lo_d = off - hs;
      hi_d = off + hs;
    end else begin
      lo_d = '0;
      hi_d = $signed({4'b0000, cfg_i.joint_ceiling});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_val_q  <= val_d;
      s2_lo_q   <= lo_d;
      s2_hi_q   <= hi_d;
      s2_meta_q <= s1_meta_q;
    end
  end

  // Clamp, saturate, checksum
  always_comb begin
    clamped = s2_val_q;
    if (s2_val_q > s2_hi_q) begin
      clamped = s2_hi_q;
    end else if (s2_val_q < s2_lo_q) begin
      clamped = s2_lo_q;
    end
    if (clamped < 0) begin
      clamped = '0;
    end else if (clamped > VAL_MAX) begin
      clamped = VAL_MAX;
    end
    value = clamped[15:0];
    sum   = (s2_meta_q.first ? 8'd0 : running_sum_q) + value[15:8] + value[7:0];
  end

  // Sum keeps running even with sending off so framing stays aligned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
    end else if (s2_leave) begin
      running_sum_q <= s2_meta_q.last ? 8'd0 : sum;
    end
  end

  assign push_valid_o      = s2_v_q && cfg_i.send_enable;
  assign push_item_o.value = value;
  assign push_item_o.sum   = sum;
  assign push_item_o.first = s2_meta_q.first;
  assign push_item_o.last  = s2_meta_q.last;

endmodule
`default_nettype wire

// ----- rtl/sapf_queue.sv -----
`default_nettype none
`include "servo_angle_packet_framer_top_defines.svh"
module sapf_queue import sapf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

  `SAPF_ASSERT_NEVER(a_q_overfill, count_q > (QUEUE_AW+1)'(QUEUE_DEPTH), "queue overfilled")
  `SAPF_ASSERT(a_q_grow, (push && !pop) |=> (count_q == $past(count_q) + (QUEUE_AW+1)'(1)), "queue count did not grow on push")
  `SAPF_ASSERT(a_q_empty_ptrs, (count_q == '0) |-> (rd_ptr_q == wr_ptr_q), "empty queue with pointers apart")

endmodule
`default_nettype wire

// ----- rtl/sapf_back.sv -----
`default_nettype none
module sapf_back import sapf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] start_byte_i,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  wire item_t      pop_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_done_o
);

  // Bytes already sent from the head entry
  logic [1:0] phase_q, phase_d;
  pos_e       pos, end_pos;
  logic       at_end, fire;

  assign pos     = pos_e'(phase_q + {1'b0, !pop_item_i.first});
  assign end_pos = pop_item_i.last ? POS_SUM : POS_LOW;
  assign at_end  = (pos == end_pos);
  assign fire    = pop_valid_i && out_ready_i;

  // Byte select
  always_comb begin
    unique case (pos)
      POS_START: out_byte_o = start_byte_i;
      POS_HIGH:  out_byte_o = pop_item_i.value[15:8];
      POS_LOW:   out_byte_o = pop_item_i.value[7:0];
      POS_SUM:   out_byte_o = pop_item_i.sum;
      default:   out_byte_o = pop_item_i.sum;
    endcase
  end

  assign out_valid_o = pop_valid_i;
  assign out_last_o  = at_end;
  assign out_done_o  = (pos == POS_SUM);
  assign pop_ready_o = out_ready_i && at_end;

  // Phase step per sent word
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      phase_d = at_end ? 2'd0 : (phase_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire
